[hdl/shell_word_lexer_macros.svh]
// Assertion macros used by the shell word lexer checker.
`ifndef SHELL_WORD_LEXER_MACROS_SVH
`define SHELL_WORD_LEXER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SWL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shell_word_lexer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define SWL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shell_word_lexer: next-cycle check failed");

`endif

[hdl/swl_pkg.sv]
// Shared codes, character constants and types of the shell word lexer.
`default_nettype none
package swl_pkg;

	// lexer mode codes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_WORD   = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	// characters the lexer reacts to
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_LOWER_T = 8'h74;

	// one result item
	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       token_done;
	} swl_result_t;

	// lexer state
	typedef struct packed {
		logic [1:0] lex_mode;
		logic       escape_pending;
	} swl_state_t;

endpackage
`default_nettype wire

[hdl/swl_step.sv]
// Per-byte lexer step: next state and result item for one input byte.
`default_nettype none
module swl_step (
	input  wire logic [7:0]          in_byte,
	input  wire logic                is_last,
	input  wire swl_pkg::swl_state_t cur,
	output swl_pkg::swl_state_t      nxt,
	output swl_pkg::swl_result_t     res,
	output logic                     has_result
);

	logic is_ws;
	logic hc;
	logic done;
	logic [7:0] ch;
	logic [1:0] mode_n;
	logic esc_n;

	// whitespace is 0x09..0x0D and space
	assign is_ws = (in_byte == swl_pkg::CH_SPACE) ||
		((in_byte >= 8'h09) && (in_byte <= 8'h0D));

	// decode one byte against the current mode
	always_comb begin
		mode_n = cur.lex_mode;
		esc_n  = cur.escape_pending;
		hc     = 1'b0;
		done   = 1'b0;
		ch     = 8'h00;
		unique case (cur.lex_mode)
			swl_pkg::MODE_WORD, swl_pkg::MODE_QUOTED: begin
				if (cur.escape_pending) begin
					esc_n = 1'b0;
					if (in_byte == swl_pkg::CH_SPACE || in_byte == swl_pkg::CH_QUOTE) begin
						hc = 1'b1;
						ch = in_byte;
					end else if (in_byte == swl_pkg::CH_LOWER_T) begin
						hc = 1'b1;
						ch = swl_pkg::CH_TAB;
					end
				end else if (in_byte == swl_pkg::CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (cur.lex_mode == swl_pkg::MODE_QUOTED) begin
					if (in_byte == swl_pkg::CH_QUOTE) begin
						done   = 1'b1;
						mode_n = swl_pkg::MODE_IDLE;
					end else begin
						hc = 1'b1;
						ch = in_byte;
					end
				end else begin
					if (is_ws) begin
						done   = 1'b1;
						mode_n = swl_pkg::MODE_IDLE;
					end else if (in_byte != swl_pkg::CH_QUOTE) begin
						hc = 1'b1;
						ch = in_byte;
					end
				end
			end
			default: begin
				// idle, and the unused code acts as idle
				mode_n = swl_pkg::MODE_IDLE;
				esc_n  = 1'b0;
				if (is_ws) begin
					mode_n = swl_pkg::MODE_IDLE;
				end else if (in_byte == swl_pkg::CH_QUOTE) begin
					mode_n = swl_pkg::MODE_QUOTED;
				end else if (in_byte == swl_pkg::CH_BSLASH) begin
					mode_n = swl_pkg::MODE_WORD;
					esc_n  = 1'b1;
				end else begin
					mode_n = swl_pkg::MODE_WORD;
					hc     = 1'b1;
					ch     = in_byte;
				end
			end
		endcase
		// close an open token on the final byte
		if (is_last) begin
			if (mode_n != swl_pkg::MODE_IDLE) begin
				done = 1'b1;
			end
			mode_n = swl_pkg::MODE_IDLE;
			esc_n  = 1'b0;
		end
	end

	assign nxt.lex_mode       = mode_n;
	assign nxt.escape_pending = esc_n;
	assign res.char_valid     = hc;
	assign res.out_char       = ch;
	assign res.token_done     = done;
	assign has_result         = hc | done;

endmodule
`default_nettype wire

[hdl/swl_out.sv]
// Result register of the shell word lexer, holding one item for the master side.
`default_nettype none
module swl_out (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire swl_pkg::swl_result_t res,
	output logic                      free,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,
	output logic                      m_tlast,
	output logic                      m_tuser
);

	logic                 valid_q;
	swl_pkg::swl_result_t res_q;

	// room for a new item when empty or when the held one leaves now
	assign free = !valid_q || m_tready;

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// hold the payload until taken
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = res_q.out_char;
	assign m_tlast  = res_q.token_done;
	assign m_tuser  = res_q.char_valid;

endmodule
`default_nettype wire

[hdl/shell_word_lexer.sv]
// Top level of the shell word lexer: input register, lexer step and result register.
// Each byte is held in the input register and its result is registered in the result register.
// Throughput: one byte per cycle unless a result finds the result register full and stalled.
// Bytes that yield no result are consumed without using the result register.
// Reset (arst_n low, asynchronous): both stages empty, mode idle, no escape pending.
`default_nettype none
module shell_word_lexer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // is_last
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_char
	output logic            m_tlast,   // token_done
	output logic            m_tuser    // char_valid
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	swl_pkg::swl_state_t  state_q;
	swl_pkg::swl_state_t  state_n;
	swl_pkg::swl_result_t res;
	logic                 has_result;
	logic                 out_free;
	logic                 advance;

	// the held byte moves on when its result has room, or when it has none
	assign advance  = valid_s1 && (!has_result || out_free);
	assign s_tready = !valid_s1 || advance;

	// input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// commit the lexer state as each byte leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.lex_mode       <= swl_pkg::MODE_IDLE;
			state_q.escape_pending <= 1'b0;
		end else if (advance) begin
			state_q <= state_n;
		end
	end

	swl_step u_step (
		.in_byte    (byte_s1),
		.is_last    (last_s1),
		.cur        (state_q),
		.nxt        (state_n),
		.res        (res),
		.has_result (has_result)
	);

	swl_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && has_result),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

[hdl/swl_checker.sv]
// Port-level checks of the shell word lexer and their binding to the top level.
`default_nettype none
`include "shell_word_lexer_macros.svh"
module swl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser
);

	// a stalled result stays offered
	`SWL_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	// an item without a byte must end a token and carry a zero byte
	`SWL_ASSERT_IMP(a_empty_is_end, m_tvalid && !m_tuser, m_tlast && (m_tdata == 8'h00))
	// with the result register empty the input side never stalls
	`SWL_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
	// a result leaving frees the path for the next byte
	`SWL_ASSERT_IMP(a_ready_on_take, m_tvalid && m_tready, s_tready)

endmodule

bind shell_word_lexer swl_checker u_swl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the shell word lexer: directed and random byte streams.
module tb;

	localparam int CLK_PERIOD      = 4;
	localparam int RESET_CYCLES    = 10;
	localparam int WATCHDOG_CYCLES = 200000;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PHASE_BYTES     = 535;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	// predicted lexer state
	logic [1:0] lex_mode    = swl_pkg::MODE_IDLE;
	logic       esc_pending = 1'b0;

	// token outputs predicted but not yet seen
	swl_pkg::swl_result_t token_out_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int bytes_sent     = 0;
	int outputs_seen   = 0;
	int tokens_closed  = 0;
	int phrases_sent   = 0;

	shell_word_lexer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic is_blank(input logic [7:0] c);
		return c == swl_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Advance the predicted lexer by one byte and queue the output it causes.
	task automatic lex_step(input logic [7:0] c, input logic last);
		logic                 have_char;
		logic                 done;
		logic [7:0]           ch;
		swl_pkg::swl_result_t r;
		have_char = 1'b0;
		done      = 1'b0;
		ch        = 8'h00;
		if (lex_mode != swl_pkg::MODE_WORD && lex_mode != swl_pkg::MODE_QUOTED) begin
			lex_mode    = swl_pkg::MODE_IDLE;
			esc_pending = 1'b0;
			if (c == swl_pkg::CH_QUOTE) begin
				lex_mode = swl_pkg::MODE_QUOTED;
			end else if (c == swl_pkg::CH_BSLASH) begin
				lex_mode    = swl_pkg::MODE_WORD;
				esc_pending = 1'b1;
			end else if (!is_blank(c)) begin
				lex_mode  = swl_pkg::MODE_WORD;
				have_char = 1'b1;
				ch        = c;
			end
		end else if (esc_pending) begin
			esc_pending = 1'b0;
			if (c == swl_pkg::CH_SPACE || c == swl_pkg::CH_QUOTE) begin
				have_char = 1'b1;
				ch        = c;
			end else if (c == swl_pkg::CH_LOWER_T) begin
				have_char = 1'b1;
				ch        = swl_pkg::CH_TAB;
			end
		end else if (c == swl_pkg::CH_BSLASH) begin
			esc_pending = 1'b1;
		end else if (lex_mode == swl_pkg::MODE_QUOTED) begin
			if (c == swl_pkg::CH_QUOTE) begin
				done     = 1'b1;
				lex_mode = swl_pkg::MODE_IDLE;
			end else begin
				have_char = 1'b1;
				ch        = c;
			end
		end else begin
			if (is_blank(c)) begin
				done     = 1'b1;
				lex_mode = swl_pkg::MODE_IDLE;
			end else if (c != swl_pkg::CH_QUOTE) begin
				have_char = 1'b1;
				ch        = c;
			end
		end
		// close any open token on the final byte
		if (last) begin
			if (lex_mode != swl_pkg::MODE_IDLE)
				done = 1'b1;
			lex_mode    = swl_pkg::MODE_IDLE;
			esc_pending = 1'b0;
		end
		if (have_char || done) begin
			r.char_valid = have_char;
			r.out_char   = ch;
			r.token_done = done;
			token_out_q.push_back(r);
		end
	endtask

	// Offer one byte, idling at random first, and hold it until accepted.
	task automatic send_byte(input logic [7:0] c, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		lex_step(c, last);
		bytes_sent++;
	endtask

	// Hold the input side until every predicted output has come out.
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (token_out_q.size() != 0)
			@(posedge clk);
	endtask

	// Compare one accepted output against the oldest prediction.
	task automatic check_token_out();
		swl_pkg::swl_result_t exp_r;
		if (token_out_q.size() == 0) begin
			$error("unexpected output: char_valid %0b out_char %02h token_done %0b",
				m_tuser, m_tdata, m_tlast);
			mismatches++;
		end else begin
			exp_r = token_out_q.pop_front();
			if (m_tuser !== exp_r.char_valid) begin
				$error("char_valid: expected %0b, got %0b", exp_r.char_valid, m_tuser);
				mismatches++;
			end
			if (m_tdata !== exp_r.out_char) begin
				$error("out_char: expected %02h, got %02h", exp_r.out_char, m_tdata);
				mismatches++;
			end
			if (m_tlast !== exp_r.token_done) begin
				$error("token_done: expected %0b, got %0b", exp_r.token_done, m_tlast);
				mismatches++;
			end
			if (exp_r.token_done)
				tokens_closed++;
		end
		outputs_seen++;
	endtask

	// Check outputs on handshake and stall the output side at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_token_out();
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Mostly shell-like characters, with a few arbitrary bytes mixed in.
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 25));
			4:          return swl_pkg::CH_SPACE;
			5:          return 8'($urandom_range(9, 13));
			6:          return swl_pkg::CH_QUOTE;
			7:          return swl_pkg::CH_BSLASH;
			8:          return swl_pkg::CH_LOWER_T;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Walk through every mode, escape and final-byte case once.
	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_byte(swl_pkg::CH_SPACE, 1'b0);     // blank skipped in idle
		send_byte(8'h61, 1'b0);                 // opens a word
		send_byte(8'h0D, 1'b0);                 // carriage return ends it
		send_byte(swl_pkg::CH_QUOTE, 1'b0);     // opens a quoted token
		send_byte(swl_pkg::CH_BSLASH, 1'b0);
		send_byte(swl_pkg::CH_QUOTE, 1'b0);     // escaped quote stays inside
		send_byte(swl_pkg::CH_TAB, 1'b0);       // blank is kept when quoted
		send_byte(swl_pkg::CH_QUOTE, 1'b0);     // closes the quoted token
		send_byte(swl_pkg::CH_BSLASH, 1'b0);    // backslash opens a word
		send_byte(swl_pkg::CH_LOWER_T, 1'b0);   // escaped t gives a tab
		send_byte(swl_pkg::CH_BSLASH, 1'b0);
		send_byte(swl_pkg::CH_SPACE, 1'b0);     // escaped space does not end the word
		send_byte(swl_pkg::CH_BSLASH, 1'b0);
		send_byte(8'h41, 1'b0);                 // other escaped byte is dropped
		send_byte(swl_pkg::CH_QUOTE, 1'b0);     // bare quote in a word is dropped
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h0A, 1'b0);                 // newline ends the word
		send_byte(swl_pkg::CH_BSLASH, 1'b1);    // final byte with escape still pending
		send_byte(swl_pkg::CH_SPACE, 1'b1);     // final blank in idle: no output
		send_byte(swl_pkg::CH_QUOTE, 1'b1);     // final quote: empty token
		send_byte(8'h80, 1'b1);                 // single-byte word on the final byte
		send_byte(8'h0B, 1'b0);
		send_byte(8'h7A, 1'b0);
		send_byte(8'h0C, 1'b1);                 // final blank ends an open word
	endtask

	// Stream random phrases and some noise under the given idle and stall rates.
	task automatic test_random_phase(input int idle_pct, input int stall_pct);
		int start_bytes;
		int len;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start_bytes    = bytes_sent;
		pause_until_drained();
		while (bytes_sent - start_bytes < PHASE_BYTES) begin
			if ($urandom_range(0, 99) < 85) begin
				len = $urandom_range(1, 24);
				for (int i = 0; i < len; i++)
					send_byte(pick_char(), i == len - 1);
				phrases_sent++;
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			end
			if ($urandom_range(0, 29) == 0)
				pause_until_drained();
		end
	endtask

	task automatic test_drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (token_out_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (token_out_q.size() != 0) begin
			$error("%0d outputs never arrived", token_out_q.size());
			mismatches++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		test_reset();
		test_directed();
		test_random_phase(10, 49);
		test_random_phase(49, 10);
		test_random_phase(0, 0);
		test_drain();
		$display("Sent %0d bytes (%0d random phrases), checked %0d outputs closing %0d tokens.",
			bytes_sent, phrases_sent, outputs_seen, tokens_closed);
		$display("Idle and stall rates of 10/49, 49/10 and 0/0 percent were exercised.");
		if (mismatches == 0) begin
			$display("shell_word_lexer regression: pass");
		end else begin
			$display("shell_word_lexer regression: fail");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#(WATCHDOG_CYCLES * CLK_PERIOD);
		$display("shell_word_lexer regression: fail");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/swl_pkg.sv
hdl/swl_step.sv
hdl/swl_out.sv
hdl/shell_word_lexer.sv
hdl/swl_checker.sv
sim/tb.sv
